// File: src/json_structural_indexer_assert.svh
// ----------------------------------------------------------------------------
// json structural indexer assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef JSON_STRUCTURAL_INDEXER_ASSERT_SVH
`define JSON_STRUCTURAL_INDEXER_ASSERT_SVH

// same-cycle implication
`define JSI_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed (same cycle)");

// next-cycle implication
`define JSI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed (next cycle)");

`endif

// File: src/jsi_pkg.sv
// ----------------------------------------------------------------------------
// jsi_pkg
// types and constants shared by the json structural indexer
// ----------------------------------------------------------------------------
`default_nettype none

package jsi_pkg;

  localparam int BYTES_PER_ITEM = 8;
  localparam int LANES_MAX      = 8;
  localparam int LANE_IDX_W     = 3;
  localparam int POSITION_BITS  = 32;

  localparam logic [31:0] POS_MASK = (POSITION_BITS >= 32) ? 32'hFFFF_FFFF :
                                     32'((64'd1 << POSITION_BITS) - 64'd1);

  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_COMMA    = 8'h2C;

  typedef struct packed {
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [7:0]  byte3;
    logic [7:0]  byte4;
    logic [7:0]  byte5;
    logic [7:0]  byte6;
    logic [7:0]  byte7;
    logic [31:0] base_position;
  } item_t;

  typedef struct packed {
    logic [31:0] position;
    logic        has_structural;
    logic [7:0]  string_mask;
    logic [7:0]  structural_mask;
    logic        last;
  } result_t;

  typedef struct packed {
    logic quote;
    logic backslash;
    logic structural;
  } lane_flags_t;

  typedef struct packed {
    logic [LANES_MAX-1:0] string_mask;
    logic [LANES_MAX-1:0] structural_mask;
    logic                 escape_out;
    logic                 in_string_out;
  } scan_t;

endpackage

`default_nettype wire

// File: src/jsi_lane.sv
// ----------------------------------------------------------------------------
// jsi_lane
// classifies one text byte as quote, backslash or structural character
// ----------------------------------------------------------------------------
`default_nettype none

module jsi_lane
  import jsi_pkg::*;
(
  input  wire logic [7:0]  ch,
  output lane_flags_t      flags
);

  always_comb begin
    flags.quote      = (ch == CH_QUOTE);
    flags.backslash  = (ch == CH_BSLASH);
    flags.structural = ch inside {CH_LBRACE, CH_RBRACE, CH_LBRACKET,
                                  CH_RBRACKET, CH_COLON, CH_COMMA};
  end

endmodule

`default_nettype wire

// File: src/jsi_scan.sv
// ----------------------------------------------------------------------------
// jsi_scan
// merges lane flags with the carries into string and structural masks
// ----------------------------------------------------------------------------
`default_nettype none

module jsi_scan
  import jsi_pkg::*;
(
  input  wire lane_flags_t [LANES_MAX-1:0] flags,
  input  wire logic                        escape_in,
  input  wire logic                        in_string_in,
  output scan_t                            scan
);

  always_comb begin
    logic esc;
    logic str;
    logic escaped;
    esc     = escape_in;
    str     = in_string_in;
    escaped = 1'b0;
    scan    = '0;
    for (int i = 0; i < LANES_MAX; i++) begin
      if (i < BYTES_PER_ITEM) begin
        escaped = esc;
        esc     = !escaped && flags[i].backslash;
        if (flags[i].quote && !escaped) begin
          str = !str;
        end
        scan.string_mask[i]     = str;
        scan.structural_mask[i] = !str && flags[i].structural;
      end
    end
    scan.escape_out    = esc;
    scan.in_string_out = str;
  end

endmodule

`default_nettype wire

// File: src/jsi_emit.sv
// ----------------------------------------------------------------------------
// jsi_emit
// holds one scanned item, sends a result per structural byte or one if none
// ----------------------------------------------------------------------------
`default_nettype none

module jsi_emit
  import jsi_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire scan_t       scan,
  input  wire logic [31:0] base_position,
  output logic             free,
  output logic             result_valid,
  input  wire logic        result_ready,
  output result_t          result
);

  logic                  full;
  logic [LANES_MAX-1:0]  pending;
  logic [LANES_MAX-1:0]  smask;
  logic [LANES_MAX-1:0]  tmask;
  logic [31:0]           base;
  logic [LANE_IDX_W-1:0] idx;
  logic                  is_last;
  logic                  xfer;

  always_comb begin
    idx = '0;
    for (int i = LANES_MAX - 1; i >= 0; i--) begin
      if (pending[i]) begin
        idx = LANE_IDX_W'(i);
      end
    end
  end

  assign is_last = ((pending & (pending - 1'b1)) == '0);
  assign xfer    = full && result_ready;
  assign free    = !full || (result_ready && is_last);

  always_comb begin
    result.has_structural  = (pending != '0);
    result.position        = result.has_structural ?
                             ((base + 32'(idx)) & POS_MASK) : 32'd0;
    result.string_mask     = 8'(smask);
    result.structural_mask = 8'(tmask);
    result.last            = is_last;
  end

  assign result_valid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (xfer && is_last) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pending <= scan.structural_mask;
      smask   <= scan.string_mask;
      tmask   <= scan.structural_mask;
      base    <= base_position;
    end else if (xfer) begin
      pending <= pending & (pending - 1'b1);
    end
  end

endmodule

`default_nettype wire

// File: src/json_structural_indexer.sv
// ----------------------------------------------------------------------------
// json_structural_indexer
// finds structural characters outside strings in json text, eight bytes a
// transfer, and reports their document positions
// ----------------------------------------------------------------------------
//  channel   direction  payload   transfer on
//  item      in         item_t    item_valid & item_ready
//  result    out        result_t  result_valid & result_ready
//
//  an item is scanned in the cycle it is taken; its results follow from the
//  output register one per cycle while taken, at least one per item
//  item_ready stays high while the last result of the held item is taken,
//  so while results are taken items without or with one structural byte
//  run at one per cycle; one with n structural bytes holds the output until
//  its n results go; reset clears escape and string carries, empties output
// ----------------------------------------------------------------------------
`default_nettype none

module json_structural_indexer
  import jsi_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_ready,
  input  wire item_t   item,
  output logic         result_valid,
  input  wire logic    result_ready,
  output result_t      result
);

  logic [LANES_MAX-1:0][7:0] bytes;
  lane_flags_t [LANES_MAX-1:0] flags;
  scan_t scan;
  logic  escape_carry;
  logic  in_string_carry;
  logic  load;

  assign bytes = {item.byte7, item.byte6, item.byte5, item.byte4,
                  item.byte3, item.byte2, item.byte1, item.byte0};

  for (genvar g = 0; g < LANES_MAX; g++) begin : g_lane
    jsi_lane u_lane (
      .ch    (bytes[g]),
      .flags (flags[g])
    );
  end

  jsi_scan u_scan (
    .flags        (flags),
    .escape_in    (escape_carry),
    .in_string_in (in_string_carry),
    .scan         (scan)
  );

  assign load = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_carry    <= 1'b0;
      in_string_carry <= 1'b0;
    end else if (load) begin
      escape_carry    <= scan.escape_out;
      in_string_carry <= scan.in_string_out;
    end
  end

  jsi_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .scan          (scan),
    .base_position (item.base_position),
    .free          (item_ready),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result        (result)
  );

endmodule

`default_nettype wire

// File: src/jsi_checker.sv
// ----------------------------------------------------------------------------
// jsi_checker
// port-level checks for the json structural indexer
// ----------------------------------------------------------------------------
`default_nettype none

`include "json_structural_indexer_assert.svh"

module jsi_checker
  import jsi_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    item_valid,
  input wire logic    item_ready,
  input wire item_t   item,
  input wire logic    result_valid,
  input wire logic    result_ready,
  input wire result_t result
);

  // held result stays put
  `JSI_ASSERT_NEXT(a_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(result))

  // empty result is the only one of its item
  `JSI_ASSERT_NOW(a_empty, clk, rst, result_valid && !result.has_structural, result.last && (result.position == 32'd0) && (result.structural_mask == 8'd0))

  // structural bytes never lie inside strings
  `JSI_ASSERT_NOW(a_mask, clk, rst, result_valid && result.has_structural, (result.structural_mask != 8'd0) && ((result.structural_mask & result.string_mask) == 8'd0))

  // more results of the same item follow at once
  `JSI_ASSERT_NEXT(a_more, clk, rst, result_valid && result_ready && !result.last, result_valid && result.has_structural)

  // waiting item transfer stays put
  `JSI_ASSERT_NEXT(a_item_hold, clk, rst, item_valid && !item_ready, item_valid && $stable(item))

endmodule

bind json_structural_indexer jsi_checker u_jsi_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .item         (item),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

`default_nettype wire
